[rtl/knock_pattern_matcher_top_macros.svh]
// assertion macros shared by the knock matcher rtl
// each macro expects clk and arst_n in the enclosing module
`ifndef KNOCK_PATTERN_MATCHER_TOP_MACROS_SVH
`define KNOCK_PATTERN_MATCHER_TOP_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define KPM_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kpm assertion failed");
// condition at one edge implies another at the next edge
`define KPM_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kpm assertion failed");
`else
`define KPM_ASSERT(name, cond)
`define KPM_ASSERT_NEXT(name, pre, post)
`endif

`endif

[rtl/kpm_pkg.sv]
`default_nettype none

package kpm_pkg;

	// pattern geometry
	localparam int MAX_INTERVALS = 8;
	localparam int SLOT_W        = $clog2(MAX_INTERVALS);
	localparam int ENTRY_W       = 8;
	localparam int PATTERN_W     = MAX_INTERVALS * ENTRY_W;

	// event queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORDS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS    = 3'd5;

	// reset values
	localparam logic [7:0]           RST_THRESHOLD      = 8'd133;
	localparam logic [7:0]           RST_UNIT_TICKS     = 8'd20;
	localparam logic [3:0]           RST_INTERVAL_COUNT = 4'd2;
	localparam logic [PATTERN_W-1:0] RST_PATTERN_WORDS  = 64'd514;
	localparam logic [15:0]          RST_TIMEOUT_TICKS  = 16'd2000;
	localparam logic [7:0]           RST_BLANK_TICKS    = 8'd8;

	// input opcode
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [1:0] {
		OUT_MATCH   = 2'd0,
		OUT_WRONG   = 2'd1,
		OUT_TIMEOUT = 2'd2
	} outcome_t;

	// classified event; quiet samples never enter the queue
	typedef enum logic {
		EV_TICK,
		EV_KNOCK
	} ev_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] sample;
	} in_item_t;

	typedef struct packed {
		logic       opened;
		logic [1:0] outcome;
		logic [3:0] knocks_seen;
	} out_item_t;

	typedef struct packed {
		logic [7:0]           threshold;
		logic [7:0]           unit_ticks;
		logic [3:0]           interval_count;
		logic [PATTERN_W-1:0] pattern_words;
		logic [15:0]          timeout_ticks;
		logic [7:0]           blank_ticks;
	} cfg_t;

	typedef struct packed {
		logic en;
		ev_t  ev;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		ev_t  ev;
	} q_rd_t;

endpackage

`default_nettype wire

[rtl/kpm_front.sv]
`default_nettype none

module kpm_front import kpm_pkg::*; (
	input  wire logic       [7:0] threshold,
	input  wire logic       push,
	output logic            full,
	input  wire in_item_t   item,
	input  wire logic       q_full,
	output q_wr_t           wr
);

	logic accept;
	logic loud;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign loud   = (item.sample >= threshold);

	// quiet samples change nothing in any state, so drop them here
	always_comb begin
		wr.en = 1'b0;
		wr.ev = EV_TICK;
		if (accept) begin
			if (item.opcode == OP_TICK) begin
				wr.en = 1'b1;
				wr.ev = EV_TICK;
			end else if (loud) begin
				wr.en = 1'b1;
				wr.ev = EV_KNOCK;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/kpm_queue.sv]
`default_nettype none

`include "knock_pattern_matcher_top_macros.svh"

module kpm_queue import kpm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_wr_t wr,
	output logic       q_full,
	input  wire logic  rd_en,
	output q_rd_t      rd
);

	ev_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full   = (cnt_q == QCNT_W'(QDEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.ev    = mem_q[rd_ptr_q];
	assign do_wr    = wr.en && !q_full;
	assign do_rd    = rd_en && rd.valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`KPM_ASSERT(a_q_cnt_bound, cnt_q <= QCNT_W'(QDEPTH))
	`KPM_ASSERT_NEXT(a_q_full_no_room, q_full && !do_rd, q_full)
	`KPM_ASSERT(a_q_wr_has_room, !(wr.en && q_full))

endmodule

`default_nettype wire

[rtl/kpm_back.sv]
`default_nettype none

`include "knock_pattern_matcher_top_macros.svh"

module kpm_back import kpm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire q_rd_t rd,
	output logic       rd_en,
	input  wire logic  pop,
	output logic       empty,
	output out_item_t  result
);

	// attempt state
	logic        capturing_q;
	logic [15:0] interval_q;
	logic [7:0]  blank_q;
	logic [3:0]  knock_idx_q;
	logic        mismatch_q;

	logic        capturing_d;
	logic [15:0] interval_d;
	logic [7:0]  blank_d;
	logic [3:0]  knock_idx_d;
	logic        mismatch_d;

	// two-entry result buffer
	out_item_t   out_mem_q [2];
	logic        out_wr_ptr_q;
	logic        out_rd_ptr_q;
	logic [1:0]  out_cnt_q;
	logic        out_wr;
	out_item_t   out_item;
	logic        out_rd;

	logic                   go;
	logic [SLOT_W-1:0]      slot;
	logic [ENTRY_W-1:0]     entry;
	logic [15:0]            expected;
	logic [16:0]            iv_lo;
	logic [16:0]            exp_hi;
	logic                   bad_interval;
	logic [15:0]            iv_inc;
	logic [3:0]             idx_inc;
	logic [3:0]             eff_count;

	assign go    = rd.valid && (out_cnt_q != 2'd2);
	assign rd_en = go;

	assign slot     = knock_idx_q[SLOT_W-1:0];
	assign entry    = cfg.pattern_words[slot*ENTRY_W +: ENTRY_W];
	assign expected = {8'd0, entry} * {8'd0, cfg.unit_ticks};
	assign iv_lo    = {1'b0, interval_q} + {9'd0, cfg.unit_ticks[7:1]};
	assign exp_hi   = {1'b0, expected} + {9'd0, cfg.unit_ticks[7:1]};
	assign bad_interval = (iv_lo < {1'b0, expected}) || ({1'b0, interval_q} > exp_hi);

	assign iv_inc  = (interval_q != 16'hFFFF) ? interval_q + 16'd1 : interval_q;
	assign idx_inc = (knock_idx_q != 4'hF) ? knock_idx_q + 4'd1 : knock_idx_q;

	always_comb begin
		if (cfg.interval_count == 4'd0) begin
			eff_count = 4'd1;
		end else if (cfg.interval_count > 4'(MAX_INTERVALS)) begin
			eff_count = 4'(MAX_INTERVALS);
		end else begin
			eff_count = cfg.interval_count;
		end
	end

	always_comb begin
		capturing_d = capturing_q;
		interval_d  = interval_q;
		blank_d     = blank_q;
		knock_idx_d = knock_idx_q;
		mismatch_d  = mismatch_q;
		out_wr      = 1'b0;
		out_item    = '0;
		if (go) begin
			case (rd.ev)
				EV_TICK: begin
					if (capturing_q) begin
						blank_d    = (blank_q != 8'd0) ? blank_q - 8'd1 : blank_q;
						interval_d = iv_inc;
						if (iv_inc >= cfg.timeout_ticks) begin
							out_wr               = 1'b1;
							out_item.opened      = 1'b0;
							out_item.outcome     = OUT_TIMEOUT;
							out_item.knocks_seen = knock_idx_q;
							capturing_d          = 1'b0;
							interval_d           = 16'd0;
							blank_d              = 8'd0;
						end
					end
				end
				EV_KNOCK: begin
					if (!capturing_q) begin
						capturing_d = 1'b1;
						interval_d  = 16'd0;
						knock_idx_d = 4'd0;
						mismatch_d  = 1'b0;
						blank_d     = cfg.blank_ticks;
					end else if (blank_q == 8'd0) begin
						mismatch_d  = mismatch_q || bad_interval;
						knock_idx_d = idx_inc;
						interval_d  = 16'd0;
						blank_d     = cfg.blank_ticks;
						if (idx_inc >= eff_count) begin
							out_wr               = 1'b1;
							out_item.opened      = !mismatch_d;
							out_item.outcome     = mismatch_d ? OUT_WRONG : OUT_MATCH;
							out_item.knocks_seen = idx_inc;
							capturing_d          = 1'b0;
							blank_d              = 8'd0;
						end
					end
				end
				default: begin
					capturing_d = capturing_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			interval_q  <= 16'd0;
			blank_q     <= 8'd0;
			knock_idx_q <= 4'd0;
			mismatch_q  <= 1'b0;
		end else begin
			capturing_q <= capturing_d;
			interval_q  <= interval_d;
			blank_q     <= blank_d;
			knock_idx_q <= knock_idx_d;
			mismatch_q  <= mismatch_d;
		end
	end

	// result buffer
	assign empty  = (out_cnt_q == 2'd0);
	assign result = out_mem_q[out_rd_ptr_q];
	assign out_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_mem_q[out_wr_ptr_q] <= out_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_ptr_q <= 1'b0;
			out_rd_ptr_q <= 1'b0;
			out_cnt_q    <= 2'd0;
		end else begin
			if (out_wr) begin
				out_wr_ptr_q <= !out_wr_ptr_q;
			end
			if (out_rd) begin
				out_rd_ptr_q <= !out_rd_ptr_q;
			end
			case ({out_wr, out_rd})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	`KPM_ASSERT(a_out_cnt_bound, out_cnt_q <= 2'd2)
	`KPM_ASSERT(a_idle_counters_clear, capturing_q || (interval_q == 16'd0 && blank_q == 8'd0))
	`KPM_ASSERT(a_idx_bound, !capturing_q || knock_idx_q < 4'(MAX_INTERVALS))
	`KPM_ASSERT_NEXT(a_result_ends_attempt, out_wr, !capturing_q && !empty)

endmodule

`default_nettype wire

[rtl/knock_pattern_matcher_top.sv]
//  channel   direction  handshake                 payload
//  item      in         push / full               in_item_t  {opcode, sample}
//  result    out        pop / empty               out_item_t {opened, outcome, knocks_seen}
//  config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one item per clock sustained while the result side keeps up; a result
//  appears on the result ports once the item that ends an attempt has passed
//  the event queue entry, then the result buffer register
//  arst_n clears all control state and loads the register reset values
//  a stalled result side fills the two-entry result buffer, then the four-entry
//  event queue, and only then raises full
`default_nettype none

module knock_pattern_matcher_top import kpm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item channel
	input  wire logic                 push,
	output logic                      full,
	input  wire in_item_t             item,
	// result channel
	output logic                      empty,
	input  wire logic                 pop,
	output out_item_t                 result,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PATTERN_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_rd_en;

	// registers must only be written while the block is idle; the block does not enforce this, so always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= RST_THRESHOLD;
			cfg_q.unit_ticks     <= RST_UNIT_TICKS;
			cfg_q.interval_count <= RST_INTERVAL_COUNT;
			cfg_q.pattern_words  <= RST_PATTERN_WORDS;
			cfg_q.timeout_ticks  <= RST_TIMEOUT_TICKS;
			cfg_q.blank_ticks    <= RST_BLANK_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:      cfg_q.threshold      <= cfg_data[7:0];
				REG_UNIT_TICKS:     cfg_q.unit_ticks     <= cfg_data[7:0];
				REG_INTERVAL_COUNT: cfg_q.interval_count <= cfg_data[3:0];
				REG_PATTERN_WORDS:  cfg_q.pattern_words  <= cfg_data;
				REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data[15:0];
				REG_BLANK_TICKS:    cfg_q.blank_ticks    <= cfg_data[7:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// front: accept and classify each transfer into tick, knock or nothing
	kpm_front u_front (
		.threshold (cfg_q.threshold),
		.push      (push),
		.full      (full),
		.item      (item),
		.q_full    (q_full),
		.wr        (q_wr)
	);

	// short event queue decoupling the two halves
	kpm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.q_full (q_full),
		.rd_en  (q_rd_en),
		.rd     (q_rd)
	);

	// back: attempt state, interval check and result buffer
	kpm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.rd     (q_rd),
		.rd_en  (q_rd_en),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

`default_nettype wire
